// ===== sv/matrix_chain_order_dp_core_assert.svh =====
// assertion macros for the matrix chain order core checker
// no dependencies; included by the checker file only, which provides aclk and aresetn
`ifndef MATRIX_CHAIN_ORDER_DP_CORE_ASSERT_SVH
`define MATRIX_CHAIN_ORDER_DP_CORE_ASSERT_SVH

// checked outside reset
`define MCODP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define MCODP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/mcodp_pkg.sv =====
// shared widths, constants and the evaluator control type
// of the matrix chain order core; no dependencies
package mcodp_pkg;

    localparam int DIM_FIELD_W = 10;
    localparam int S_TDATA_W   = 16;
    localparam int IDX_FIELD_W = 4;
    localparam int COST_W      = 40;
    localparam int SPLIT_W     = 3;
    localparam int M_TDATA_W   = 56;
    localparam int M_PAD_W     = M_TDATA_W - 2 * IDX_FIELD_W - COST_W - SPLIT_W;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // control from the sequencer to the evaluator
    typedef struct packed {
        logic                   init;    // dimension pair valid, start a new subchain
        logic                   valid;   // split candidate issued this cycle
        logic                   diag_a;  // left part is a single matrix
        logic                   diag_b;  // right part is a single matrix
        logic [IDX_FIELD_W-1:0] k;       // split candidate, or subchain start on init
    } eval_ctrl_t;

endpackage

// ===== sv/mcodp_ram.sv =====
// simple dual read, single write synchronous memory with registered read data
// used for the dimension store and the cost table; depends on nothing
module mcodp_ram #(
    parameter int W     = 10,
    parameter int AW    = 4,
    parameter int DEPTH = 9
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic [AW-1:0] rd0_addr,
    input  logic [AW-1:0] rd1_addr,
    output logic [W-1:0]  rd0_data,
    output logic [W-1:0]  rd1_data
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule

// ===== sv/mcodp_eval.sv =====
// split evaluator: product of three dimensions, saturating cost sum and
// running minimum over the split candidates; uses mcodp_pkg
module mcodp_eval
    import mcodp_pkg::*;
#(
    parameter int SW = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  eval_ctrl_t             ctrl,
    input  logic [SW-1:0]          dim_a,      // d[i-1], valid on init
    input  logic [SW-1:0]          dim_b,      // d[j] on init, d[k] the cycle after issue
    input  logic [COST_W-1:0]      cost_a,     // cost of left part, the cycle after issue
    input  logic [COST_W-1:0]      cost_b,     // cost of right part, the cycle after issue
    output logic [COST_W-1:0]      best_cost,
    output logic [IDX_FIELD_W-1:0] best_split
);

    localparam int PW  = 3 * SW;
    localparam int PXW = (PW > COST_W) ? PW : COST_W;

    eval_ctrl_t c0_reg, c1_reg;

    logic [2*SW-1:0]        pij_reg;
    logic [PW-1:0]          prod_reg;
    logic [COST_W-1:0]      sum_reg;
    logic [COST_W-1:0]      best_reg, best_next;
    logic [IDX_FIELD_W-1:0] split_reg, split_next;

    logic [COST_W-1:0] ca, cb, prod_sat, q;
    logic [COST_W:0]   s1, s2;
    logic [PXW-1:0]    prod_x;

    // stage one: memory data of the issued candidate
    always_comb begin
        ca = c0_reg.diag_a ? '0 : cost_a;
        cb = c0_reg.diag_b ? '0 : cost_b;
        s1 = {1'b0, ca} + {1'b0, cb};
    end

    // stage two: full candidate cost and compare
    always_comb begin
        prod_x   = PXW'(prod_reg);
        prod_sat = (prod_x > PXW'(COST_MAX)) ? COST_MAX : prod_x[COST_W-1:0];
        s2       = {1'b0, sum_reg} + {1'b0, prod_sat};
        q        = s2[COST_W] ? COST_MAX : s2[COST_W-1:0];
        best_next  = best_reg;
        split_next = split_reg;
        if (ctrl.init) begin
            best_next  = COST_MAX;
            split_next = ctrl.k;
        end else if (c1_reg.valid && (q < best_reg)) begin
            best_next  = q;
            split_next = c1_reg.k;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg <= '0;
            c1_reg <= '0;
        end else begin
            c0_reg <= ctrl;
            c1_reg <= c0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.init) begin
            pij_reg <= dim_a * dim_b;
        end
        prod_reg  <= pij_reg * dim_b;
        sum_reg   <= s1[COST_W] ? COST_MAX : s1[COST_W-1:0];
        best_reg  <= best_next;
        split_reg <= split_next;
    end

    assign best_cost  = best_reg;
    assign best_split = split_reg;

endmodule

// ===== sv/matrix_chain_order_dp_core.sv =====
// Matrix chain order core. Dimensions arrive one beat each on the slave
// stream, the beat with tlast closing the chain; n = dimensions - 1 matrices.
// Loading takes one beat per cycle. After the last beat the core fills the
// cost table for every subchain by increasing length, then start, and sends
// one result beat per subchain of two or more matrices, the whole chain last
// with m_tlast. A chain of one matrix gives one zero-cost beat (start = end
// = 1), a lone dimension gives one beat with start = end = 0. Costs saturate
// at all ones, the smallest split reaching the least cost is reported, and
// m_tuser flags a chain whose extra dimensions beyond MAX_MATRICES + 1 were
// dropped. Each subchain runs through the dimension pair read, the pair
// product, one split candidate per cycle through the cost-table read ports,
// the pipeline drain states and the write-back, which waits while a result
// beat stalls on m_tready. Memories need no clearing pass; the core is
// ready right after reset. The slave side stays ready while the last result
// beat waits on the master side.
module matrix_chain_order_dp_core
    import mcodp_pkg::*;
#(
    parameter int MAX_MATRICES = 8,
    parameter int DIM_BITS     = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] dimension, rest zero
    input  logic                 s_tlast,   // last_dimension
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [3:0] chain_start, [7:4] chain_end,
                                            // [47:8] least_cost, [50:48] best_split
    output logic                 m_tlast,   // final_result
    output logic                 m_tuser    // chain_too_long
);

    localparam int IW        = $clog2(MAX_MATRICES + 1);
    localparam int CNTW      = $clog2(MAX_MATRICES + 2);
    localparam int CW        = $clog2(MAX_MATRICES);
    localparam int SW        = (DIM_BITS < DIM_FIELD_W) ? DIM_BITS : DIM_FIELD_W;
    localparam int DIM_DEPTH = MAX_MATRICES + 1;
    localparam int COST_AW   = 2 * CW;
    localparam int COST_DEPTH = 1 << COST_AW;

    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(MAX_MATRICES + 1);
    localparam logic [IW-1:0]   N_MAX    = IW'(MAX_MATRICES);
    localparam logic [IW-1:0]   ONE      = IW'(1);
    localparam logic [IW-1:0]   TWO      = IW'(2);

    // sequencer states
    localparam logic [2:0] ST_LOAD   = 3'd0;  // taking dimension beats
    localparam logic [2:0] ST_SHORT  = 3'd1;  // chain of zero or one matrix
    localparam logic [2:0] ST_PREP   = 3'd2;  // read d[i-1] and d[j]
    localparam logic [2:0] ST_MUL    = 3'd3;  // form d[i-1] * d[j]
    localparam logic [2:0] ST_RUN    = 3'd4;  // issue one split candidate a cycle
    localparam logic [2:0] ST_DRAIN1 = 3'd5;
    localparam logic [2:0] ST_DRAIN2 = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;  // write back and send the result

    logic [2:0]      state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic            run_ovf_reg, run_ovf_next;
    logic [IW-1:0]   n_reg, n_next;
    logic [IW-1:0]   len_reg, len_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [IW-1:0]   k_reg, k_next;

    // output beat register
    logic                   m_valid_reg, m_valid_next;
    logic [IDX_FIELD_W-1:0] start_reg, end_reg;
    logic [COST_W-1:0]      cost_reg;
    logic [SPLIT_W-1:0]     split_reg;
    logic                   last_reg, user_reg;
    logic                   out_load;

    logic            s_accept, out_free, store_dim;
    logic [IW-1:0]   j_idx;

    logic [IW-1:0]   dim_rd0_addr, dim_rd1_addr;
    logic [SW-1:0]   dim_rd0, dim_rd1;
    logic [COST_AW-1:0] cost_rd_a_addr, cost_rd_b_addr, cost_wr_addr;
    logic [COST_W-1:0]  cost_rd_a, cost_rd_b;
    logic               cost_wr_en;

    eval_ctrl_t             ctrl;
    logic [COST_W-1:0]      best_cost;
    logic [IDX_FIELD_W-1:0] best_split;

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign store_dim = (cnt_reg < CNT_FULL);
    assign j_idx     = i_reg + len_reg - ONE;

    // dimension store: written while loading, read as a pair then per split
    assign dim_rd0_addr = i_reg - ONE;
    assign dim_rd1_addr = (state_reg == ST_RUN) ? k_reg : j_idx;

    mcodp_ram #(
        .W     (SW),
        .AW    (IW),
        .DEPTH (DIM_DEPTH)
    ) u_dim_ram (
        .aclk     (aclk),
        .wr_en    (s_accept && store_dim),
        .wr_addr  (IW'(cnt_reg)),
        .wr_data  (s_tdata[SW-1:0]),
        .rd0_addr (dim_rd0_addr),
        .rd1_addr (dim_rd1_addr),
        .rd0_data (dim_rd0),
        .rd1_data (dim_rd1)
    );

    // cost table, row = start - 1, column = end - 1; diagonal entries are
    // never stored, the evaluator reads them as zero. Every entry read in a
    // subchain belongs to a shorter one, written back before this one starts.
    assign cost_rd_a_addr = {CW'(i_reg - ONE), CW'(k_reg - ONE)};
    assign cost_rd_b_addr = {CW'(k_reg), CW'(j_idx - ONE)};
    assign cost_wr_addr   = {CW'(i_reg - ONE), CW'(j_idx - ONE)};
    assign cost_wr_en     = (state_reg == ST_DONE) && out_free;

    mcodp_ram #(
        .W     (COST_W),
        .AW    (COST_AW),
        .DEPTH (COST_DEPTH)
    ) u_cost_ram (
        .aclk     (aclk),
        .wr_en    (cost_wr_en),
        .wr_addr  (cost_wr_addr),
        .wr_data  (best_cost),
        .rd0_addr (cost_rd_a_addr),
        .rd1_addr (cost_rd_b_addr),
        .rd0_data (cost_rd_a),
        .rd1_data (cost_rd_b)
    );

    always_comb begin
        ctrl.init   = (state_reg == ST_MUL);
        ctrl.valid  = (state_reg == ST_RUN);
        ctrl.diag_a = (k_reg == i_reg);
        ctrl.diag_b = (k_reg == j_idx - ONE);
        ctrl.k      = (state_reg == ST_MUL) ? IDX_FIELD_W'(i_reg) : IDX_FIELD_W'(k_reg);
    end

    mcodp_eval #(
        .SW (SW)
    ) u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .dim_a      (dim_rd0),
        .dim_b      (dim_rd1),
        .cost_a     (cost_rd_a),
        .cost_b     (cost_rd_b),
        .best_cost  (best_cost),
        .best_split (best_split)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        run_ovf_next = run_ovf_reg;
        n_next       = n_reg;
        len_next     = len_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        out_load     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (store_dim) begin
                        cnt_next = cnt_reg + CNTW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        // count after this beat, minus one
                        n_next       = store_dim ? IW'(cnt_reg) : N_MAX;
                        run_ovf_next = ovf_reg || !store_dim;
                        cnt_next     = '0;
                        ovf_next     = 1'b0;
                        len_next     = TWO;
                        i_next       = ONE;
                        if (store_dim ? (cnt_reg <= CNTW'(1)) : (N_MAX <= ONE)) begin
                            state_next = ST_SHORT;
                        end else begin
                            state_next = ST_PREP;
                        end
                    end
                end
            end
            ST_SHORT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_PREP: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                k_next     = i_reg;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (k_reg == j_idx - ONE) begin
                    state_next = ST_DRAIN1;
                end else begin
                    k_next = k_reg + ONE;
                end
            end
            ST_DRAIN1: begin
                state_next = ST_DRAIN2;
            end
            ST_DRAIN2: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (j_idx == n_reg) begin
                        if (len_reg == n_reg) begin
                            state_next = ST_LOAD;
                        end else begin
                            len_next   = len_reg + ONE;
                            i_next     = ONE;
                            state_next = ST_PREP;
                        end
                    end else begin
                        i_next     = i_reg + ONE;
                        state_next = ST_PREP;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = out_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            run_ovf_reg <= 1'b0;
            n_reg       <= '0;
            len_reg     <= '0;
            i_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            run_ovf_reg <= run_ovf_next;
            n_reg       <= n_next;
            len_reg     <= len_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            user_reg <= run_ovf_reg;
            last_reg <= (state_reg == ST_SHORT) || (len_reg == n_reg);
            if (state_reg == ST_SHORT) begin
                start_reg <= IDX_FIELD_W'(n_reg);
                end_reg   <= IDX_FIELD_W'(n_reg);
                cost_reg  <= '0;
                split_reg <= '0;
            end else begin
                start_reg <= IDX_FIELD_W'(i_reg);
                end_reg   <= IDX_FIELD_W'(j_idx);
                cost_reg  <= best_cost;
                split_reg <= best_split[SPLIT_W-1:0];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, split_reg, cost_reg, end_reg, start_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

// ===== sv/mcodp_checker.sv =====
// port-level checker for the matrix chain order core and its bind
// depends on mcodp_pkg and matrix_chain_order_dp_core_assert.svh
`include "matrix_chain_order_dp_core_assert.svh"

module mcodp_checker
    import mcodp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser
);

    logic [IDX_FIELD_W-1:0] start_f, end_f;
    logic [COST_W-1:0]      cost_f;
    logic [M_TDATA_W+1:0]   payload;
    logic                   same_ends;

    assign start_f   = m_tdata[IDX_FIELD_W-1:0];
    assign end_f     = m_tdata[2*IDX_FIELD_W-1:IDX_FIELD_W];
    assign cost_f    = m_tdata[2*IDX_FIELD_W+COST_W-1:2*IDX_FIELD_W];
    assign payload   = {m_tuser, m_tlast, m_tdata};
    assign same_ends = (start_f == end_f);

    // no result beat right after reset
    `MCODP_ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    // a stalled beat stays and holds its payload
    `MCODP_ASSERT(a_valid_holds, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")
    `MCODP_ASSERT(a_data_holds, m_tvalid && !m_tready |=> $stable(payload), "payload moved")

    // a single matrix, or none, costs nothing
    `MCODP_ASSERT(a_single_zero_cost, m_tvalid && same_ends |-> (cost_f == '0), "zero cost")

    // the whole-chain beat starts at the first matrix, or at zero for no matrix
    `MCODP_ASSERT(a_final_start, m_tvalid && m_tlast |-> (start_f <= 4'd1), "bad final start")

endmodule

bind matrix_chain_order_dp_core mcodp_checker u_mcodp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== test/tb_matrix_chain_order_dp_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for matrix_chain_order_dp_core: dimension chains in,
// one result beat per subchain out, checked against an in-bench cost predictor
// depends on mcodp_pkg and the core rtl
module tb_matrix_chain_order_dp_core;
    import mcodp_pkg::*;

    localparam int MAX_MAT       = 8;
    localparam int DIM_SLOTS     = MAX_MAT + 1;
    localparam int ITEM_TARGET   = 280;
    localparam int HOLD_CYCLES   = 300;
    // the tail after the last expected beat covers a stray beat
    localparam int DRAIN_CYCLES  = 64;
    // longest correct quiet stretch is the receiver hold, several times over
    localparam int QUIET_LIMIT   = 2000;

    localparam int END_LSB   = IDX_FIELD_W;
    localparam int COST_LSB  = 2 * IDX_FIELD_W;
    localparam int SPLIT_LSB = COST_LSB + COST_W;

    localparam logic [DIM_FIELD_W-1:0] DIM_LOW  = 1;
    localparam logic [DIM_FIELD_W-1:0] DIM_HIGH = {DIM_FIELD_W{1'b1}};

    // one expected result beat
    typedef struct packed {
        logic [IDX_FIELD_W-1:0] first_matrix;
        logic [IDX_FIELD_W-1:0] last_matrix;
        logic [COST_W-1:0]      cost;
        logic [SPLIT_W-1:0]     split;
        logic                   whole_chain;
        logic                   dropped;
    } subchain_cost_t;

    // directed stimulus row; typed rows carry the result written out by hand
    typedef struct packed {
        logic [DIM_FIELD_W-1:0] dim;
        logic                   last;
        logic                   typed;
        subchain_cost_t         res;
    } dim_row_t;

    localparam subchain_cost_t NO_RES = '0;

    localparam dim_row_t DIRECTED_ROWS [24] = '{
        // lone dimension, no matrix at all
        '{10'd1023, 1'b1, 1'b1, '{4'd0, 4'd0, 40'd0, 3'd0, 1'b1, 1'b0}},
        // single matrix
        '{10'd1,    1'b0, 1'b0, NO_RES},
        '{10'd1,    1'b1, 1'b1, '{4'd1, 4'd1, 40'd0, 3'd0, 1'b1, 1'b0}},
        // two matrices at the largest dimension
        '{10'd1023, 1'b0, 1'b0, NO_RES},
        '{10'd1023, 1'b0, 1'b0, NO_RES},
        '{10'd1023, 1'b1, 1'b1, '{4'd1, 4'd2, 40'd1070599167, 3'd1, 1'b1, 1'b0}},
        // two matrices at the smallest dimension
        '{10'd1,    1'b0, 1'b0, NO_RES},
        '{10'd1,    1'b0, 1'b0, NO_RES},
        '{10'd1,    1'b1, 1'b1, '{4'd1, 4'd2, 40'd1, 3'd1, 1'b1, 1'b0}},
        // eleven dimensions: the last two are dropped, chain flagged too long
        '{10'd30,   1'b0, 1'b0, NO_RES},
        '{10'd35,   1'b0, 1'b0, NO_RES},
        '{10'd512,  1'b0, 1'b0, NO_RES},
        '{10'd5,    1'b0, 1'b0, NO_RES},
        '{10'd10,   1'b0, 1'b0, NO_RES},
        '{10'd20,   1'b0, 1'b0, NO_RES},
        '{10'd341,  1'b0, 1'b0, NO_RES},
        '{10'd40,   1'b0, 1'b0, NO_RES},
        '{10'd682,  1'b0, 1'b0, NO_RES},
        '{10'd60,   1'b0, 1'b0, NO_RES},
        '{10'd70,   1'b1, 1'b0, NO_RES},
        // equal dimensions: every split ties, the smallest must win
        '{10'd7,    1'b0, 1'b0, NO_RES},
        '{10'd7,    1'b0, 1'b0, NO_RES},
        '{10'd7,    1'b0, 1'b0, NO_RES},
        '{10'd7,    1'b1, 1'b0, NO_RES}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    // predictor state: the chain being loaded and the cost table
    logic [DIM_FIELD_W-1:0] chain_dims [DIM_SLOTS];
    int unsigned            dims_held    = 0;
    logic                   dims_dropped = 1'b0;
    logic [COST_W-1:0]      cost_tab [MAX_MAT][MAX_MAT];

    subchain_cost_t pending_costs [$];
    int             mismatches   = 0;
    int             items_sent   = 0;
    int             quiet_cycles = 0;
    int             send_calm    = 0;
    int             recv_calm    = 0;
    bit             hold_request = 1'b0;

    matrix_chain_order_dp_core #(
        .MAX_MATRICES (MAX_MAT),
        .DIM_BITS     (DIM_FIELD_W)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [9:0] dimension, rest zero
        .s_tlast  (s_tlast),    // last_dimension
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [3:0] start, [7:4] end, [47:8] cost, [50:48] split
        .m_tlast  (m_tlast),    // final_result
        .m_tuser  (m_tuser)     // chain_too_long
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // random wait before the next beat, with occasional runs of no gaps
    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic longint unsigned cost_sum(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > COST_MAX) ? COST_MAX : s;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        mismatches++;
    endtask

    // offer one dimension beat, then run the predictor on it once accepted
    task automatic offer_beat(input logic [DIM_FIELD_W-1:0] dim, input logic last,
                              input logic typed, input subchain_cost_t typed_res);
        int              gap;
        int unsigned     n, len, i, j, k, best_k;
        longint unsigned best, prod, q;
        subchain_cost_t  r;
        gap = pick_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(dim);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;

        // store, or drop and flag once capacity is used up
        if (dims_held < DIM_SLOTS) begin
            chain_dims[dims_held] = dim;
            dims_held++;
        end else begin
            dims_dropped = 1'b1;
        end
        if (!last) return;

        n = dims_held - 1;
        if (typed) begin
            pending_costs.push_back(typed_res);
        end else if (n == 0) begin
            r = '{4'd0, 4'd0, '0, 3'd0, 1'b1, dims_dropped};
            pending_costs.push_back(r);
        end else if (n == 1) begin
            r = '{4'd1, 4'd1, '0, 3'd0, 1'b1, dims_dropped};
            pending_costs.push_back(r);
        end else begin
            for (i = 0; i < n; i++) cost_tab[i][i] = '0;
            // by increasing length, then start; strict less keeps the first split
            for (len = 2; len <= n; len++) begin
                for (i = 1; i + len - 1 <= n; i++) begin
                    j      = i + len - 1;
                    best   = COST_MAX;
                    best_k = i;
                    for (k = i; k < j; k++) begin
                        prod = 64'(chain_dims[i-1]) * 64'(chain_dims[k]) * 64'(chain_dims[j]);
                        if (prod > COST_MAX) prod = COST_MAX;
                        q = cost_sum(cost_sum(cost_tab[i-1][k-1], cost_tab[k][j-1]), prod);
                        if (q < best) begin
                            best   = q;
                            best_k = k;
                        end
                    end
                    cost_tab[i-1][j-1] = COST_W'(best);
                    r.first_matrix = IDX_FIELD_W'(i);
                    r.last_matrix  = IDX_FIELD_W'(j);
                    r.cost         = COST_W'(best);
                    r.split        = SPLIT_W'(best_k);
                    r.whole_chain  = (len == n);
                    r.dropped      = dims_dropped;
                    pending_costs.push_back(r);
                end
            end
        end
        dims_held    = 0;
        dims_dropped = 1'b0;
    endtask

    // sender: directed table, then random chains
    initial begin
        int                     count, mode, pick, c;
        logic [DIM_FIELD_W-1:0] base, dim;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[row]) begin
            offer_beat(DIRECTED_ROWS[row].dim, DIRECTED_ROWS[row].last,
                       DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].res);
        end

        // receiver stalls hard early on, so the core backs up into its input
        hold_request = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) count = 1;
            else if (pick < 3) count = 2;
            else if (pick < 17) count = $urandom_range(3, DIM_SLOTS);
            else count = $urandom_range(DIM_SLOTS + 1, DIM_SLOTS + 3);
            mode = $urandom_range(0, 3);
            base = DIM_FIELD_W'($urandom_range(DIM_LOW, DIM_HIGH));
            for (c = 0; c < count; c++) begin
                case (mode)
                    0: begin
                        dim = DIM_FIELD_W'($urandom_range(DIM_LOW, DIM_HIGH));
                    end
                    1: begin
                        dim = DIM_FIELD_W'($urandom_range(1, 16));
                    end
                    2: begin
                        dim = $urandom_range(0, 1) ? DIM_LOW : DIM_HIGH;
                    end
                    default: begin
                        dim = base;
                    end
                endcase
                offer_beat(dim, c == count - 1, 1'b0, NO_RES);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_costs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // receiver: random stalls per beat, one long hold when asked
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = pick_wait(recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // result beats against the oldest expectation
    always @(posedge aclk) begin
        subchain_cost_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_costs.size() == 0) begin
                flag_mismatch($sformatf("unexpected result beat %h", m_tdata));
            end else begin
                want = pending_costs.pop_front();
                if (m_tdata[0 +: IDX_FIELD_W] !== want.first_matrix)
                    flag_mismatch($sformatf("chain_start got %0d want %0d",
                                  m_tdata[0 +: IDX_FIELD_W], want.first_matrix));
                if (m_tdata[END_LSB +: IDX_FIELD_W] !== want.last_matrix)
                    flag_mismatch($sformatf("chain_end got %0d want %0d",
                                  m_tdata[END_LSB +: IDX_FIELD_W], want.last_matrix));
                if (m_tdata[COST_LSB +: COST_W] !== want.cost)
                    flag_mismatch($sformatf("least_cost %0d..%0d got %0d want %0d",
                                  want.first_matrix, want.last_matrix,
                                  m_tdata[COST_LSB +: COST_W], want.cost));
                if (m_tdata[SPLIT_LSB +: SPLIT_W] !== want.split)
                    flag_mismatch($sformatf("best_split %0d..%0d got %0d want %0d",
                                  want.first_matrix, want.last_matrix,
                                  m_tdata[SPLIT_LSB +: SPLIT_W], want.split));
                if (m_tlast !== want.whole_chain)
                    flag_mismatch($sformatf("m_tlast %0d..%0d got %b want %b",
                                  want.first_matrix, want.last_matrix,
                                  m_tlast, want.whole_chain));
                if (m_tuser !== want.dropped)
                    flag_mismatch($sformatf("m_tuser %0d..%0d got %b want %b",
                                  want.first_matrix, want.last_matrix,
                                  m_tuser, want.dropped));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

endmodule
